@@ design/assert_macros.svh @@
// Assertion macros shared by the expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define MBRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Clocked check that also holds during reset.
`define MBRE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: check failed");

`endif

@@ design/mbre_pkg.sv @@
// Shared types and constants for the bitmap to RGB expander.
`default_nettype none

package mbre_pkg;

  localparam int unsigned ROWS_DEF   = 16;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned ROW_PIX    = 32;
  localparam int unsigned COL_W      = 5;
  localparam int unsigned PAT_DEPTH  = 256;
  localparam int unsigned PAL_DEPTH  = 16;
  localparam int unsigned PAL_AW     = 4;

  typedef enum logic [2:0] {
    FUNC_MIRROR   = 3'd0,
    FUNC_PATTERN  = 3'd1,
    FUNC_PLAIN    = 3'd2,
    FUNC_OVERDUB  = 3'd3,
    FUNC_LOAD_PAT = 3'd4,
    FUNC_LOAD_COL = 3'd5
  } func_e;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] idx;
    logic [PIX_W-1:0]  data;
  } pal_wr_t;

endpackage

`default_nettype wire

@@ design/mbre_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module mbre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/mbre_palette.sv @@
// Sixteen-entry colour table held in flops, with combinational lookup.
`default_nettype none

module mbre_palette (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mbre_pkg::pal_wr_t                wr_i,
  input  wire logic [mbre_pkg::PAL_AW-1:0]      idx_i,
  output logic      [mbre_pkg::PIX_W-1:0]       colour_o
);

  logic [mbre_pkg::PIX_W-1:0] pal_q [mbre_pkg::PAL_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mbre_pkg::PAL_DEPTH); i++) begin
        pal_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      pal_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign colour_o = pal_q[idx_i];

endmodule

`default_nettype wire

@@ design/mono_bitmap_to_rgb_expander.sv @@
// Top level: expands a 16-bit monochrome row into 32 RGB pixels for a two-half panel.
//
// A row item (modes mirrored solid, patterned, unmirrored solid, overdub) is taken and
// then produces 32 pixel results, one per cycle while the output is not stalled. The
// rate is set by the frame store, which is read and written back one pixel per cycle
// through its single read and single write port. Pattern and colour loads, ignored
// function codes and rows at or beyond ROWS are taken and produce nothing. After reset
// the frame store and pattern store are cleared by a sweep over both stores, during
// which in_stall_o stays high.
`default_nettype none
`include "assert_macros.svh"

module mono_bitmap_to_rgb_expander #(
  parameter int unsigned ROWS = mbre_pkg::ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [3:0]  row_index_i,
  input  wire logic [15:0] row_bits_i,
  input  wire logic [23:0] solid_colour_i,
  input  wire logic [3:0]  hue_offset_i,
  input  wire logic [7:0]  table_index_i,
  input  wire logic [23:0] table_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       pixel_row_o,
  output logic [4:0]       pixel_column_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       green_o,
  output logic [7:0]       red_o,
  output logic             last_pixel_o
);

  localparam int unsigned FRAME_DEPTH = ROWS * mbre_pkg::ROW_PIX;
  localparam int unsigned FRAME_AW    = $clog2(FRAME_DEPTH);
  localparam int unsigned PAT_AW      = $clog2(mbre_pkg::PAT_DEPTH);
  localparam int unsigned CLR_LEN     = (FRAME_DEPTH > mbre_pkg::PAT_DEPTH) ?
                                        FRAME_DEPTH : mbre_pkg::PAT_DEPTH;
  localparam int unsigned CLR_AW      = $clog2(CLR_LEN);
  localparam int unsigned COL_W       = mbre_pkg::COL_W;
  localparam int unsigned PIX_W       = mbre_pkg::PIX_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e              state_q, state_d;
  logic [CLR_AW-1:0]   clr_q, clr_d;
  logic [2:0]          func_q, func_d;
  logic [3:0]          row_q, row_d;
  logic [15:0]         bits_q, bits_d;
  logic [PIX_W-1:0]    solid_q, solid_d;
  logic [3:0]          offset_q, offset_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic                s2_valid_q, s2_valid_d;
  logic [COL_W-1:0]    s2_col_q, s2_col_d;
  logic                out_valid_q, out_valid_d;
  logic [3:0]          out_row_q, out_row_d;
  logic [COL_W-1:0]    out_col_q, out_col_d;
  logic [PIX_W-1:0]    out_pix_q, out_pix_d;

  logic                accept, issue, s2_mv, out_free, pix_on, row_ok;
  logic [3:0]          bit_pos, pal_idx;
  logic [PIX_W-1:0]    pix_c, pal_colour, frame_rdata;
  logic [3:0]          pat_rdata;
  mbre_pkg::pal_wr_t   pal_wr;

  logic                frame_we, pat_we;
  logic [FRAME_AW-1:0] frame_waddr, frame_raddr;
  logic [PIX_W-1:0]    frame_wdata;
  logic [PAT_AW-1:0]   pat_waddr, pat_raddr;
  logic [3:0]          pat_wdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = (state_q == ST_RUN) && (!s2_valid_q || out_free);
  assign s2_mv      = s2_valid_q && out_free;
  assign row_ok     = 32'(row_index_i) < ROWS;

  // second half is mirrored unless the unmirrored mode is running
  assign bit_pos = (!s2_col_q[COL_W-1] || func_q == mbre_pkg::FUNC_PLAIN) ?
                   ~s2_col_q[3:0] : s2_col_q[3:0];
  assign pix_on  = bits_q[bit_pos];
  assign pal_idx = offset_q + pat_rdata;

  always_comb begin
    if (pix_on) begin
      pix_c = (func_q == mbre_pkg::FUNC_PATTERN) ? pal_colour : solid_q;
    end else begin
      pix_c = (func_q == mbre_pkg::FUNC_OVERDUB) ? frame_rdata : '0;
    end
  end

  // memory ports: the clearing sweep owns them until it ends
  always_comb begin
    frame_we    = 1'b0;
    frame_waddr = FRAME_AW'({row_q, s2_col_q});
    frame_wdata = pix_c;
    pat_we      = 1'b0;
    pat_waddr   = table_index_i;
    pat_wdata   = table_value_i[3:0];
    if (state_q == ST_CLEAR) begin
      frame_we    = 32'(clr_q) < FRAME_DEPTH;
      frame_waddr = clr_q[FRAME_AW-1:0];
      frame_wdata = '0;
      pat_we      = 32'(clr_q) < mbre_pkg::PAT_DEPTH;
      pat_waddr   = clr_q[PAT_AW-1:0];
      pat_wdata   = '0;
    end else begin
      frame_we = s2_mv;
      pat_we   = accept && (func_i == mbre_pkg::FUNC_LOAD_PAT);
    end
  end

  assign frame_raddr = FRAME_AW'({row_q, col_q});
  assign pat_raddr   = {row_q, col_q[3:0]};

  assign pal_wr.en   = accept && (func_i == mbre_pkg::FUNC_LOAD_COL) &&
                       (table_index_i < 8'(mbre_pkg::PAL_DEPTH));
  assign pal_wr.idx  = table_index_i[mbre_pkg::PAL_AW-1:0];
  assign pal_wr.data = table_value_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    row_d       = row_q;
    bits_d      = bits_q;
    solid_d     = solid_q;
    offset_d    = offset_q;
    col_d       = col_q;
    s2_valid_d  = s2_valid_q;
    s2_col_d    = s2_col_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_pix_d   = out_pix_q;

    if (s2_mv) begin
      out_valid_d = 1'b1;
      out_row_d   = row_q;
      out_col_d   = s2_col_q;
      out_pix_d   = pix_c;
      s2_valid_d  = 1'b0;
    end
    if (issue) begin
      s2_valid_d = 1'b1;
      s2_col_d   = col_q;
      col_d      = col_q + 1'b1;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_AW'(CLR_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && row_ok && (func_i inside {mbre_pkg::FUNC_MIRROR,
            mbre_pkg::FUNC_PATTERN, mbre_pkg::FUNC_PLAIN, mbre_pkg::FUNC_OVERDUB})) begin
          func_d   = func_i;
          row_d    = row_index_i;
          bits_d   = row_bits_i;
          solid_d  = solid_colour_i;
          offset_d = hue_offset_i;
          col_d    = '0;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && col_q == COL_W'(mbre_pkg::ROW_PIX - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_mv) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      func_q      <= '0;
      row_q       <= '0;
      bits_q      <= '0;
      solid_q     <= '0;
      offset_q    <= '0;
      col_q       <= '0;
      s2_valid_q  <= 1'b0;
      s2_col_q    <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_pix_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      func_q      <= func_d;
      row_q       <= row_d;
      bits_q      <= bits_d;
      solid_q     <= solid_d;
      offset_q    <= offset_d;
      col_q       <= col_d;
      s2_valid_q  <= s2_valid_d;
      s2_col_q    <= s2_col_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_pix_q   <= out_pix_d;
    end
  end

  mbre_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frame_wdata),
    .re_i    (issue),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  mbre_ram #(
    .WIDTH (4),
    .DEPTH (mbre_pkg::PAT_DEPTH)
  ) u_pattern (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .re_i    (issue),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  mbre_palette u_palette (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (pal_wr),
    .idx_i    (pal_idx),
    .colour_o (pal_colour)
  );

  assign out_valid_o    = out_valid_q;
  assign pixel_row_o    = out_row_q;
  assign pixel_column_o = out_col_q;
  assign blue_o         = out_pix_q[23:16];
  assign green_o        = out_pix_q[15:8];
  assign red_o          = out_pix_q[7:0];
  assign last_pixel_o   = (out_col_q == COL_W'(mbre_pkg::ROW_PIX - 1));

  // a pixel waiting on a stalled output keeps its column and RAM data
  `MBRE_ASSERT(a_s2_hold, s2_valid_q && !out_free |=> s2_valid_q && $stable(s2_col_q))
  `MBRE_ASSERT(a_drain_busy, state_q == ST_DRAIN |-> s2_valid_q)
  `MBRE_ASSERT_ALWAYS(a_clear_quiet, state_q == ST_CLEAR |-> !out_valid_o && !s2_valid_q)

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the monochrome row to RGB pixel expander.
`timescale 1ns / 100ps

module tb;
  import mbre_pkg::*;

  localparam int unsigned HALF_PIX = ROW_PIX / 2;
  localparam logic [2:0] FUNC_RSVD_LO = 3'd6;
  localparam logic [2:0] FUNC_RSVD_HI = 3'd7;
  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 7;
  localparam int PHASE_ITEMS = 40;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 50000;
  localparam int TAIL_CYCLES = 40;
  localparam int DIR_ROWS = 25;
  localparam longint LIMIT_NS = 2000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  row;
    logic [15:0] bits;
    logic [23:0] solid;
    logic [3:0]  offset;
    logic [7:0]  tindex;
    logic [23:0] tvalue;
  } request_t;

  typedef struct packed {
    logic [3:0] row;
    logic [4:0] col;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } pixel_t;

  // fixed: results typed in below (n_px pixels, all of one colour) instead of predicted
  typedef struct packed {
    request_t    req;
    logic        fixed;
    logic [5:0]  n_px;
    logic [23:0] colour;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func = '0;
  logic [3:0]  row_index = '0;
  logic [15:0] row_bits = '0;
  logic [23:0] solid_colour = '0;
  logic [3:0]  hue_offset = '0;
  logic [7:0]  table_index = '0;
  logic [23:0] table_value = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [3:0]  pixel_row_o;
  logic [4:0]  pixel_column_o;
  logic [7:0]  blue_o;
  logic [7:0]  green_o;
  logic [7:0]  red_o;
  logic        last_pixel_o;

  // predictor state
  logic [23:0] frame_mem [ROWS_DEF * ROW_PIX];
  logic [3:0]  pat_mem [PAT_DEPTH];
  logic [23:0] pal_mem [PAL_DEPTH];

  pixel_t      pending_px [$];
  int          errors = 0;
  int unsigned send_idle_pct = 32;
  int unsigned stall_pct = 65;
  int          holdoff_reqs = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{FUNC_MIRROR,   4'd0,  16'h0000, 24'hffffff, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd32, 24'h0},
    '{'{FUNC_PATTERN,  4'd5,  16'hffff, 24'h000000, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd32, 24'h0},
    '{'{FUNC_OVERDUB,  4'd3,  16'h0000, 24'hffffff, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd32, 24'h0},
    '{'{FUNC_MIRROR,   4'd15, 16'hffff, 24'hffffff, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd32,
      24'hffffff},
    '{'{FUNC_PLAIN,    4'd0,  16'hffff, 24'hff0000, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd32,
      24'hff0000},
    '{'{FUNC_MIRROR,   4'd1,  16'h8001, 24'h00ff00, 4'd0,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    '{'{FUNC_PLAIN,    4'd1,  16'h8001, 24'h0000ff, 4'd0,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    '{'{FUNC_MIRROR,   4'd2,  16'ha5c3, 24'h5a5a5a, 4'd0,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    '{'{FUNC_PLAIN,    4'd4,  16'ha5c3, 24'ha5a5a5, 4'd0,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    // high bits of a pattern value are dropped
    '{'{FUNC_LOAD_PAT, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h00, 24'hfffff7}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_PAT, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'hff, 24'h00000f}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_PAT, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h21, 24'h000009}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_PAT, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'hf0, 24'h00000e}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_COL, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h00, 24'hffffff}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_COL, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h0f, 24'h800080}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_COL, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h07, 24'h00ff00}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_COL, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h06, 24'h0000ff}, 1'b1, 6'd0,
      24'h0},
    // colour index out of range: ignored
    '{'{FUNC_LOAD_COL, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'h10, 24'habcdef}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_LOAD_COL, 4'd0,  16'h0000, 24'h000000, 4'd0,  8'hff, 24'h123456}, 1'b1, 6'd0,
      24'h0},
    '{'{FUNC_PATTERN,  4'd0,  16'hffff, 24'h000000, 4'd0,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    '{'{FUNC_PATTERN,  4'd15, 16'h7ffe, 24'h000000, 4'd15, 8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    '{'{FUNC_PATTERN,  4'd2,  16'h0f0f, 24'h000000, 4'd8,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    '{'{FUNC_OVERDUB,  4'd2,  16'h00ff, 24'h00ffff, 4'd0,  8'h00, 24'h0}, 1'b0, 6'd0, 24'h0},
    // unused function codes: nothing out
    '{'{FUNC_RSVD_LO,  4'd0,  16'hffff, 24'hffffff, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd0, 24'h0},
    '{'{FUNC_RSVD_HI,  4'd9,  16'hffff, 24'hffffff, 4'd0,  8'h00, 24'h0}, 1'b1, 6'd0, 24'h0}
  };

  mono_bitmap_to_rgb_expander uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .func_i         (func),
    .row_index_i    (row_index),
    .row_bits_i     (row_bits),
    .solid_colour_i (solid_colour),
    .hue_offset_i   (hue_offset),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .blue_o         (blue_o),
    .green_o        (green_o),
    .red_o          (red_o),
    .last_pixel_o   (last_pixel_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
  end

  // Updates the tables and frame store for one request and returns the pixels it emits.
  function automatic void expand_row(input request_t r, output pixel_t px[$]);
    logic [23:0] colour;
    logic [3:0]  k;
    logic [3:0]  hue;
    logic        lit;
    int unsigned addr;
    px = {};
    case (r.func)
      FUNC_LOAD_PAT: pat_mem[r.tindex] = r.tvalue[3:0];
      FUNC_LOAD_COL: if (r.tindex < PAL_DEPTH) pal_mem[r.tindex[3:0]] = r.tvalue;
      FUNC_MIRROR, FUNC_PATTERN, FUNC_PLAIN, FUNC_OVERDUB: begin
        if (r.row < ROWS_DEF) begin
          for (int col = 0; col < ROW_PIX; col++) begin
            k = 4'(col);
            // second half is bit-reversed except in the unmirrored mode
            lit = (col < HALF_PIX || r.func == FUNC_PLAIN) ? r.bits[4'd15 - k] : r.bits[k];
            addr = r.row * ROW_PIX + col;
            if (r.func == FUNC_PATTERN) begin
              hue = r.offset + pat_mem[{r.row, k}];
              colour = lit ? pal_mem[hue] : '0;
            end else if (r.func == FUNC_OVERDUB) begin
              colour = lit ? r.solid : frame_mem[addr];
            end else begin
              colour = lit ? r.solid : '0;
            end
            frame_mem[addr] = colour;
            px.push_back('{r.row, 5'(col), colour[23:16], colour[15:8], colour[7:0],
                           col == ROW_PIX - 1});
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input dir_row_t d);
    pixel_t px[$];
    in_valid     <= 1'b1;
    func         <= d.req.func;
    row_index    <= d.req.row;
    row_bits     <= d.req.bits;
    solid_colour <= d.req.solid;
    hue_offset   <= d.req.offset;
    table_index  <= d.req.tindex;
    table_value  <= d.req.tvalue;
    do @(posedge clk_i); while (in_stall_o);
    expand_row(d.req, px);
    if (d.fixed) begin
      for (int c = 0; c < d.n_px; c++)
        pending_px.push_back('{d.req.row, 5'(c), d.colour[23:16], d.colour[15:8],
                               d.colour[7:0], c == ROW_PIX - 1});
    end else begin
      foreach (px[i]) pending_px.push_back(px[i]);
    end
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  int holdoff_served = 0;
  int holdoff_left = 0;
  always @(posedge clk_i) begin
    if (holdoff_reqs != holdoff_served) begin
      holdoff_served = holdoff_reqs;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = '{pixel_row_o, pixel_column_o, blue_o, green_o, red_o, last_pixel_o};
      if (pending_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel row %0d col %0d bgr %h %h %h last %b", $time,
                 got.row, got.col, got.blue, got.green, got.red, got.last);
      end else begin
        want = pending_px.pop_front();
        if (got != want) begin
          errors++;
          $display("%0t: mismatch expected row %0d col %0d bgr %h %h %h last %b, %s",
                   $time, want.row, want.col, want.blue, want.green, want.red, want.last,
                   $sformatf("got row %0d col %0d bgr %h %h %h last %b", got.row, got.col,
                             got.blue, got.green, got.red, got.last));
        end
      end
    end
  end

  initial begin
    request_t    r;
    int          counted;
    int          sent;
    int unsigned pick;
    int          wait_cycles;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i]);
      sender_gap();
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 32; stall_pct = 65; end
        1: begin send_idle_pct = 65; stall_pct = 32; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      counted = 0;
      sent = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        r.row = 4'($urandom);
        r.solid = 24'($urandom);
        r.offset = 4'($urandom);
        r.tindex = 8'($urandom);
        r.tvalue = 24'($urandom);
        case ($urandom_range(7))
          0: r.bits = '1;
          1: r.bits = '0;
          default: r.bits = 16'($urandom);
        endcase
        if (pick < 62) begin
          r.func = 3'($urandom_range(int'(FUNC_OVERDUB)));
        end else if (pick < 76) begin
          r.func = FUNC_LOAD_PAT;
        end else if (pick < 92) begin
          r.func = FUNC_LOAD_COL;
          if ($urandom_range(3) != 0) r.tindex = 8'($urandom_range(PAL_DEPTH - 1));
        end else begin
          r.func = $urandom_range(1) ? FUNC_RSVD_HI : FUNC_RSVD_LO;
        end
        if (!(r.func == FUNC_RSVD_LO || r.func == FUNC_RSVD_HI ||
              (r.func == FUNC_LOAD_COL && r.tindex >= PAL_DEPTH)))
          counted++;
        send_request('{r, 1'b0, 6'd0, 24'd0});
        sent++;
        // back up the output while requests keep coming
        if (ph == 2 && sent == 12) holdoff_reqs++;
        if (ph == 1 && sent == 20) begin
          while (pending_px.size() != 0) begin
            in_valid <= 1'b0;
            @(posedge clk_i);
          end
        end
        sender_gap();
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_px.size() != 0 && wait_cycles < DRAIN_CYCLES) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_px.size() != 0) begin
      errors++;
      $display("%0t: expected %0d more pixels, got none", $time, pending_px.size());
    end
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
